@@ sv/skrc_pkg.sv @@
// ----------------------------------------------------------------------------
// skrc_pkg
// Shared types and constants for the session keepalive reconnect controller.
// ----------------------------------------------------------------------------
package skrc_pkg;

  localparam int MAX_FAILURES = 7;
  localparam int FC_W         = $clog2(MAX_FAILURES + 1);
  localparam int BASE_W       = 17;
  localparam int CFG_W        = 20;
  localparam int DLY_W        = BASE_W + MAX_FAILURES - 1;
  localparam int CNT_W        = 5;

  localparam logic [31:0] FLOOR_SPAN    = 32'd4001;
  localparam logic [63:0] FLOOR_BASE_MS = 64'd1000;
  // 4096 modulo the floor span, and the fold count that brings any 32-bit
  // word below twice the span.
  localparam logic [31:0] FLOOR_FOLD    = 32'd95;
  localparam logic [2:0]  FOLD_STEPS    = 3'd4;

  localparam logic [15:0] CODE_AUTH_FAIL    = 16'd4004;
  localparam logic [15:0] CODE_FATAL_LO     = 16'd4010;
  localparam logic [15:0] CODE_FATAL_HI     = 16'd4014;
  localparam logic [15:0] CODE_BAD_SEQ      = 16'd4007;
  localparam logic [15:0] CODE_SESS_TIMEOUT = 16'd4009;
  localparam logic [15:0] CODE_NORMAL       = 16'd1000;
  localparam logic [15:0] CODE_GOING_AWAY   = 16'd1001;
  localparam logic [15:0] CODE_RATE_LIMIT   = 16'd4008;

  typedef enum logic [3:0] {
    OP_CONNECTED   = 4'd0,
    OP_HELLO       = 4'd1,
    OP_POLL        = 4'd2,
    OP_AUTH_SENT   = 4'd3,
    OP_HB_SENT     = 4'd4,
    OP_ACK         = 4'd5,
    OP_HB_REQUEST  = 4'd6,
    OP_DISPATCH    = 4'd7,
    OP_READY       = 4'd8,
    OP_DISCONNECT  = 4'd9,
    OP_INVALID     = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    PH_OFFLINE = 3'd0,
    PH_HELLO   = 3'd1,
    PH_AUTH    = 3'd2,
    PH_READY   = 3'd3,
    PH_BLOCKED = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ACT_WAIT      = 3'd0,
    ACT_CONNECT   = 3'd1,
    ACT_RECONNECT = 3'd2,
    ACT_RESUME    = 3'd3,
    ACT_IDENTIFY  = 3'd4,
    ACT_HEARTBEAT = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    REG_HELLO_TIMEOUT = 3'd0,
    REG_READY_TIMEOUT = 3'd1,
    REG_INTERVAL_MIN  = 3'd2,
    REG_INTERVAL_MAX  = 3'd3,
    REG_BACKOFF_BASE  = 3'd4,
    REG_BACKOFF_CAP   = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WAIT_A,
    ST_WAIT_B,
    ST_COMMIT
  } ctl_state_t;

  typedef struct packed {
    logic [3:0]  operation;
    logic [63:0] now_ms;
    logic [31:0] hello_interval;
    logic [31:0] random_value;
    logic [63:0] sequence_number;
    logic        resume_ok;
    logic [15:0] close_code;
  } evt_t;

  typedef struct packed {
    logic [2:0] action;
    logic       hello_accepted;
    logic [2:0] phase_now;
  } res_t;

  typedef struct packed {
    logic capture;
    logic start_a;
    logic start_b;
    logic latch_a;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_a;
    logic need_b;
    logic mod_done;
    logic out_free;
  } dp_stat_t;

endpackage

@@ sv/skrc_mod.sv @@
// ----------------------------------------------------------------------------
// skrc_mod
// Iterative 32-bit remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module skrc_mod import skrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [31:0]      dvd;
  logic [31:0]      dsr;
  logic [32:0]      trial;
  logic [32:0]      diff;

  assign trial = {remainder, dvd[31]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '1;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      dvd       <= dividend;
      dsr       <= divisor;
    end else if (busy) begin
      dvd <= {dvd[30:0], 1'b0};
      if (!diff[32]) begin
        remainder <= diff[31:0];
      end else begin
        remainder <= trial[31:0];
      end
    end
  end

endmodule

@@ sv/skrc_ctrl.sv @@
// ----------------------------------------------------------------------------
// skrc_ctrl
// Sequencer: takes a request, runs the remainder passes it needs, commits.
// ----------------------------------------------------------------------------
module skrc_ctrl import skrc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     evt_valid,
  output logic     evt_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    evt_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        evt_ready = 1'b1;
        if (evt_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.need_a) begin
          cmd.start_a = 1'b1;
          state_next  = ST_WAIT_A;
        end else begin
          state_next = ST_COMMIT;
        end
      end
      ST_WAIT_A: begin
        if (stat.mod_done) begin
          cmd.latch_a = 1'b1;
          if (stat.need_b) begin
            cmd.start_b = 1'b1;
            state_next  = ST_WAIT_B;
          end else begin
            state_next = ST_COMMIT;
          end
        end
      end
      ST_WAIT_B: begin
        if (stat.mod_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> stat.out_free)
    else $error("commit while result register is occupied");

  a_accept_goes_decode: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && evt_ready) |=> (state == ST_DECODE))
    else $error("accepted request did not enter decode");

  a_second_pass_after_first: assert property (@(posedge clk) disable iff (rst)
    cmd.start_b |-> (state == ST_WAIT_A && stat.mod_done))
    else $error("second remainder pass started out of order");

endmodule

@@ sv/skrc_dp.sv @@
// ----------------------------------------------------------------------------
// skrc_dp
// Datapath: configuration, session state, backoff math and result register.
// ----------------------------------------------------------------------------
module skrc_dp import skrc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  evt_t             evt,
  input  ctl_cmd_t         cmd,
  output dp_stat_t         stat,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res
);

  // Configuration.
  logic [CFG_W-1:0]  hello_timeout, ready_timeout, interval_min, interval_max, backoff_cap;
  logic [BASE_W-1:0] backoff_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      hello_timeout <= CFG_W'(15000);
      ready_timeout <= CFG_W'(30000);
      interval_min  <= CFG_W'(1000);
      interval_max  <= CFG_W'(300000);
      backoff_base  <= BASE_W'(1000);
      backoff_cap   <= CFG_W'(60000);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HELLO_TIMEOUT: hello_timeout <= cfg_data;
        REG_READY_TIMEOUT: ready_timeout <= cfg_data;
        REG_INTERVAL_MIN:  interval_min  <= cfg_data;
        REG_INTERVAL_MAX:  interval_max  <= cfg_data;
        REG_BACKOFF_BASE:  backoff_base  <= cfg_data[BASE_W-1:0];
        REG_BACKOFF_CAP:   backoff_cap   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured request.
  evt_t e;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      e <= evt;
    end
  end

  // Session state.
  phase_t            phase;
  logic [63:0]       hello_limit, ready_limit, ack_limit;
  logic [63:0]       next_heartbeat_time, retry_time, last_sequence;
  logic [CFG_W-1:0]  heartbeat_interval;
  logic              ack_outstanding, heartbeat_requested, auth_wanted;
  logic              session_resumable, sequence_valid;
  logic [FC_W-1:0]   failure_count;

  // Close code classes.
  logic code_fatal, code_clear, code_rate;
  assign code_fatal = (e.close_code == CODE_AUTH_FAIL) ||
                      (e.close_code >= CODE_FATAL_LO && e.close_code <= CODE_FATAL_HI);
  assign code_clear = (e.close_code == CODE_BAD_SEQ) || (e.close_code == CODE_SESS_TIMEOUT) ||
                      (e.close_code == CODE_NORMAL) || (e.close_code == CODE_GOING_AWAY);
  // Rate limit applies only to a disconnect; an invalid session runs the backoff without it.
  assign code_rate  = (op_t'(e.operation) == OP_DISCONNECT) && (e.close_code == CODE_RATE_LIMIT);

  // Backoff delay from the incremented failure count.
  logic [FC_W-1:0]  fc_next;
  logic [FC_W-1:0]  shamt;
  logic [DLY_W-1:0] raw_delay;
  logic [CFG_W-1:0] delay;
  logic [18:0]      jitter_div;

  assign fc_next   = (failure_count < FC_W'(MAX_FAILURES)) ? failure_count + 1'b1
                                                            : failure_count;
  assign shamt     = fc_next - 1'b1;
  assign raw_delay = DLY_W'(backoff_base) << shamt;
  always_comb begin
    if (code_rate || raw_delay > DLY_W'(backoff_cap)) begin
      delay = backoff_cap;
    end else begin
      delay = raw_delay[CFG_W-1:0];
    end
  end
  assign jitter_div = {1'b0, delay[CFG_W-1:2]} + 19'd1;

  logic hello_ok;
  assign hello_ok = (phase == PH_HELLO) && (e.hello_interval != '0) &&
                    (e.hello_interval >= 32'(interval_min)) &&
                    (e.hello_interval <= 32'(interval_max));

  // Remainder unit for the variable divisors.
  logic        mod_start, mod_done;
  logic [31:0] mod_divisor, mod_rem;
  assign mod_start   = cmd.start_a;
  assign mod_divisor = (op_t'(e.operation) == OP_HELLO) ? e.hello_interval
                                                         : 32'(jitter_div);

  skrc_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (e.random_value),
    .divisor   (mod_divisor),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Floor jitter: 4096 is 95 modulo 4001, so folding the high bits down four
  // times leaves a value below twice the span, and one subtract finishes it.
  logic [31:0] fold, fold_next, floor_rem;
  logic [2:0]  fold_cnt;
  logic        fold_done;

  assign fold_next = {12'd0, fold[31:12]} * FLOOR_FOLD + {20'd0, fold[11:0]};
  assign floor_rem = (fold >= FLOOR_SPAN) ? fold - FLOOR_SPAN : fold;

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_cnt  <= '0;
      fold_done <= 1'b0;
    end else begin
      fold_done <= 1'b0;
      if (cmd.start_b) begin
        fold_cnt <= FOLD_STEPS;
      end else if (fold_cnt != '0) begin
        fold_cnt <= fold_cnt - 1'b1;
        if (fold_cnt == 3'd1) begin
          fold_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_b) begin
      fold <= e.random_value;
    end else if (fold_cnt != '0) begin
      fold <= fold_next;
    end
  end

  // Results of the first pass.
  logic [63:0] retry_a;
  logic [31:0] rem_a;
  always_ff @(posedge clk) begin
    if (cmd.latch_a) begin
      rem_a   <= mod_rem;
      retry_a <= e.now_ms + 64'(delay) + 64'(mod_rem);
    end
  end

  logic [63:0] floor_time;
  assign floor_time = e.now_ms + FLOOR_BASE_MS + 64'(floor_rem);

  always_comb begin
    stat.need_a   = 1'b0;
    stat.need_b   = (op_t'(e.operation) == OP_INVALID);
    stat.mod_done = mod_done || fold_done;
    stat.out_free = !res_valid || res_ready;
    case (op_t'(e.operation))
      OP_HELLO:      stat.need_a = hello_ok;
      OP_DISCONNECT: stat.need_a = !code_fatal;
      OP_INVALID:    stat.need_a = 1'b1;
      default:       stat.need_a = 1'b0;
    endcase
  end

  // Poll decision.
  action_t poll_act;
  always_comb begin
    poll_act = ACT_WAIT;
    case (phase)
      PH_OFFLINE: if (e.now_ms >= retry_time) poll_act = ACT_CONNECT;
      PH_HELLO:   if (e.now_ms >= hello_limit) poll_act = ACT_RECONNECT;
      PH_AUTH, PH_READY: begin
        if (ack_outstanding && e.now_ms >= ack_limit) begin
          poll_act = ACT_RECONNECT;
        end else if (phase == PH_AUTH && e.now_ms >= ready_limit) begin
          poll_act = ACT_RECONNECT;
        end else if (auth_wanted) begin
          poll_act = (session_resumable && sequence_valid) ? ACT_RESUME : ACT_IDENTIFY;
        end else if (heartbeat_requested || e.now_ms >= next_heartbeat_time) begin
          poll_act = ACT_HEARTBEAT;
        end
      end
      default: poll_act = ACT_WAIT;
    endcase
  end

  // Phase after the step.
  phase_t phase_next;
  always_comb begin
    phase_next = phase;
    case (op_t'(e.operation))
      OP_CONNECTED:  phase_next = PH_HELLO;
      OP_HELLO:      if (hello_ok) phase_next = PH_AUTH;
      OP_READY:      phase_next = PH_READY;
      OP_DISCONNECT: phase_next = code_fatal ? PH_BLOCKED : PH_OFFLINE;
      OP_INVALID:    phase_next = PH_OFFLINE;
      default:       phase_next = phase;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_OFFLINE;
      hello_limit         <= '0;
      ready_limit         <= '0;
      ack_limit           <= '0;
      next_heartbeat_time <= '0;
      retry_time          <= '0;
      heartbeat_interval  <= '0;
      ack_outstanding     <= 1'b0;
      heartbeat_requested <= 1'b0;
      auth_wanted         <= 1'b0;
      session_resumable   <= 1'b0;
      sequence_valid      <= 1'b0;
      last_sequence       <= '0;
      failure_count       <= '0;
    end else if (cmd.commit) begin
      phase <= phase_next;
      case (op_t'(e.operation))
        OP_CONNECTED: begin
          hello_limit         <= e.now_ms + 64'(hello_timeout);
          ack_outstanding     <= 1'b0;
          heartbeat_requested <= 1'b0;
          auth_wanted         <= 1'b0;
        end
        OP_HELLO: begin
          if (hello_ok) begin
            heartbeat_interval  <= e.hello_interval[CFG_W-1:0];
            next_heartbeat_time <= e.now_ms + 64'(rem_a);
            auth_wanted         <= 1'b1;
            ready_limit         <= e.now_ms + 64'(ready_timeout);
          end
        end
        OP_AUTH_SENT: begin
          auth_wanted <= 1'b0;
          ready_limit <= e.now_ms + 64'(ready_timeout);
        end
        OP_HB_SENT: begin
          if (!ack_outstanding) begin
            ack_limit <= e.now_ms + 64'(heartbeat_interval);
          end
          ack_outstanding <= 1'b1;
          if (e.now_ms >= next_heartbeat_time) begin
            next_heartbeat_time <= e.now_ms + 64'(heartbeat_interval);
          end
          heartbeat_requested <= 1'b0;
        end
        OP_ACK:        ack_outstanding <= 1'b0;
        OP_HB_REQUEST: heartbeat_requested <= 1'b1;
        OP_DISPATCH: begin
          if (!sequence_valid || e.sequence_number > last_sequence) begin
            last_sequence <= e.sequence_number;
          end
          sequence_valid <= 1'b1;
        end
        OP_READY: begin
          auth_wanted       <= 1'b0;
          session_resumable <= e.resume_ok;
          failure_count     <= '0;
        end
        OP_DISCONNECT: begin
          ack_outstanding     <= 1'b0;
          heartbeat_requested <= 1'b0;
          auth_wanted         <= 1'b0;
          if (code_fatal || code_clear) begin
            session_resumable <= 1'b0;
            sequence_valid    <= 1'b0;
            last_sequence     <= '0;
          end
          if (!code_fatal) begin
            failure_count <= fc_next;
            retry_time    <= retry_a;
          end
        end
        OP_INVALID: begin
          ack_outstanding     <= 1'b0;
          heartbeat_requested <= 1'b0;
          auth_wanted         <= 1'b0;
          if (!e.resume_ok) begin
            session_resumable <= 1'b0;
            sequence_valid    <= 1'b0;
            last_sequence     <= '0;
          end
          failure_count <= fc_next;
          retry_time    <= (floor_time > retry_a) ? floor_time : retry_a;
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.commit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res.action         <= (op_t'(e.operation) == OP_POLL) ? poll_act : ACT_WAIT;
      res.hello_accepted <= (op_t'(e.operation) == OP_HELLO) && hello_ok;
      res.phase_now      <= phase_next;
    end
  end

endmodule

@@ sv/session_keepalive_reconnect_controller.sv @@
// ----------------------------------------------------------------------------
// session_keepalive_reconnect_controller
// Keepalive session controller: phases, deadlines, heartbeat and backoff.
// ----------------------------------------------------------------------------
// Each accepted request carries one timestamped event and yields exactly one
// result: the poll action, the hello verdict and the phase after the event.
// A simple event passes from the accepting edge through the decode state to
// the commit state, which writes the result register and returns the block
// to idle, ready again. An accepted hello and a non-fatal disconnect need a
// jitter remainder from a 32-bit remainder unit that retires one quotient bit
// per cycle; their result is committed once that pass is done. An
// invalid-session event also needs the 1 to 5 second floor, whose remainder
// by 4001 comes from a four-step fold after the first pass; its result is
// committed once the fold is done. One request is in flight at a time; a new
// request is taken as soon as the previous one has been committed, even while
// its result still waits in the output register for the consumer. A commit
// waits while that register holds an unconsumed result, which stalls the
// input. Configuration writes take effect at once and should only be issued
// while the block is idle.
// ----------------------------------------------------------------------------
module session_keepalive_reconnect_controller import skrc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             evt_valid,
  output logic             evt_ready,
  input  evt_t             evt,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res
);

  // Commands from the sequencer and status back from the datapath.
  ctl_cmd_t cmd;
  dp_stat_t stat;

  skrc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  skrc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt       (evt),
    .cmd       (cmd),
    .stat      (stat),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
